>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the dispatcher RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define DAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dispatcher assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define DAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dispatcher assertion failed");

`endif

>>> rtl/dad_pkg.sv
// ----------------------------------------------------------------------------
// dad_pkg
// Constants, types and codes shared by the dispatcher modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dad_pkg;

	localparam int WORKERS          = 4;
	localparam int SLOTS_PER_WORKER = 8;
	localparam int DOMAIN_BITS      = 16;

	localparam int NSLOTS        = WORKERS * SLOTS_PER_WORKER;
	localparam int WORKER_BITS   = (WORKERS > 1) ? $clog2(WORKERS) : 1;
	localparam int SLOT_IDX_BITS = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
	localparam int COUNT_BITS    = 16;
	localparam int TOTAL_BITS    = 19;
	localparam int AW_BITS       = 3;
	localparam int CHOSEN_W      = 2;
	localparam int FW_BITS       = 2;
	localparam int DOMAIN_IN_W   = 16;
	localparam int IN_TDATA_W    = 24;
	localparam int OUT_TDATA_W   = 8;

	localparam logic [AW_BITS-1:0]    ACTIVE_RESET = AW_BITS'(4);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;

	typedef logic [WORKER_BITS-1:0]   worker_idx_t;
	typedef logic [SLOT_IDX_BITS-1:0] slot_idx_t;
	typedef logic [DOMAIN_BITS-1:0]   domain_t;
	typedef logic [COUNT_BITS-1:0]    count_t;
	typedef logic [TOTAL_BITS-1:0]    total_t;

	// Request kinds
	localparam logic CMD_ASSIGN = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_NOFREE   = 2'd1,
		STS_OVERFLOW = 2'd2,
		STS_NOTHELD  = 2'd3
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic free_lookup;
		logic fin_lookup;
		logic commit;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic row_hit;
		logic scan_last;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/domain_affinity_dispatcher.sv
// Sequence: a finish request goes from acceptance to a lookup of its worker's row,
//   then commit; an assign scans active workers until a hit; a miss adds a free-slot lookup.
// Intake: a new request is taken only once the last one has committed; the
//   worker scan covers one worker row of slots per cycle.
// Reset: arst_n clears all slot valid bits, worker totals and the sequencer at once;
//   active_workers returns to 4. No clearing pass.
// ----------------------------------------------------------------------------
// domain_affinity_dispatcher
// Assigns domain-tagged tasks to workers by affinity, then by least load, and retires them on finish.
// ----------------------------------------------------------------------------
`default_nettype none

module domain_affinity_dispatcher
	import dad_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Configuration: active_workers
	input  wire logic                   cfg_we,
	input  wire logic [AW_BITS-1:0]     cfg_wdata,
	// Request stream
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // domain_id[15:0], finish_worker[17:16]
	input  wire logic                   s_axis_tuser,  // command: 0 assign, 1 finish
	// Result stream
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata   // chosen_worker[1:0], affinity_hit[2],
	                                                   // status[4:3]
);

	dp_cmd_t  cmd;
	dp_stat_t st;

	// Sequencer: accept in idle, walk active workers one row per cycle until a hit,
	// on a miss look for a free slot on the least-loaded worker (finish: look up its
	// worker's row), and commit only when the result register can take the outcome.
	dad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_finish (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.cmd       (cmd),
		.st        (st)
	);

	// Slot table, totals and result register; the result register decouples the
	// output stall from request intake, so a new request is taken while a
	// result still waits.
	dad_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_tdata  (s_axis_tdata),
		.in_tuser  (s_axis_tuser),
		.cmd       (cmd),
		.st        (st),
		.out_tdata (m_axis_tdata)
	);

endmodule

`default_nettype wire

>>> rtl/dad_datapath.sv
// ----------------------------------------------------------------------------
// dad_datapath
// Slot table, per-worker totals, row search and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dad_datapath
	import dad_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [AW_BITS-1:0]     cfg_wdata,
	input  wire logic [IN_TDATA_W-1:0]  in_tdata,
	input  wire logic                   in_tuser,
	input  wire dp_cmd_t                cmd,
	output dp_stat_t                    st,
	output logic [OUT_TDATA_W-1:0]      out_tdata
);

	logic [AW_BITS-1:0] aw_q;
	logic               cmd_q;
	domain_t            dom_q;
	logic [FW_BITS-1:0] fw_q;
	worker_idx_t        w_q;
	worker_idx_t        last_q;
	worker_idx_t        best_q;
	total_t             best_total_q;
	logic               hit_q;
	logic               found_q;
	slot_idx_t          slot_q;
	worker_idx_t        chosen_q;

	logic    valid_q  [NSLOTS];
	domain_t domain_q [NSLOTS];
	count_t  count_q  [NSLOTS];
	total_t  total_q  [WORKERS];

	logic [CHOSEN_W-1:0] out_chosen_q;
	logic                out_hit_q;
	status_t             out_status_q;

	logic        fw_ok;
	worker_idx_t fw_row;
	worker_idx_t row_sel;
	logic        row_any;
	slot_idx_t   row_slot;
	logic        free_any;
	slot_idx_t   free_slot;
	worker_idx_t last_c;

	assign fw_ok  = 32'(fw_q) < 32'(WORKERS);
	assign fw_row = worker_idx_t'(fw_q);

	// Search one worker's row of slots for the domain and for a free entry
	always_comb begin
		slot_idx_t k;
		k         = '0;
		row_any   = 1'b0;
		row_slot  = '0;
		free_any  = 1'b0;
		free_slot = '0;
		if (cmd.free_lookup) begin
			row_sel = best_q;
		end else if (cmd.fin_lookup) begin
			row_sel = fw_row;
		end else begin
			row_sel = w_q;
		end
		for (int s = 0; s < SLOTS_PER_WORKER; s++) begin
			k = slot_idx_t'(int'(row_sel) * SLOTS_PER_WORKER + s);
			if (!row_any && valid_q[k] && domain_q[k] == dom_q) begin
				row_any  = 1'b1;
				row_slot = k;
			end
			if (!free_any && !valid_q[k]) begin
				free_any  = 1'b1;
				free_slot = k;
			end
		end
	end

	assign st.row_hit   = row_any;
	assign st.scan_last = (w_q == last_q);

	// Clamp the active worker count into 1..WORKERS, kept as last index
	always_comb begin
		if (aw_q == '0) begin
			last_c = '0;
		end else if (32'(aw_q) > 32'(WORKERS)) begin
			last_c = worker_idx_t'(WORKERS - 1);
		end else begin
			last_c = worker_idx_t'(aw_q - AW_BITS'(1));
		end
	end

	// Commit decode
	logic        do_inc;
	logic        do_alloc;
	logic        do_dec;
	status_t     status_c;
	worker_idx_t tw;
	count_t      cur_count;

	assign cur_count = count_q[slot_q];

	always_comb begin
		do_inc   = 1'b0;
		do_alloc = 1'b0;
		do_dec   = 1'b0;
		status_c = STS_OK;
		tw       = chosen_q;
		if (cmd_q == CMD_FINISH) begin
			tw = fw_row;
			if (!found_q) begin
				status_c = STS_NOTHELD;
			end else begin
				do_dec = 1'b1;
			end
		end else if (hit_q) begin
			if (cur_count == COUNT_MAX) begin
				status_c = STS_OVERFLOW;
			end else begin
				do_inc = 1'b1;
			end
		end else if (!found_q) begin
			status_c = STS_NOFREE;
		end else begin
			do_alloc = 1'b1;
		end
	end

	// Control and reset-cleared state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_q <= ACTIVE_RESET;
			for (int i = 0; i < NSLOTS; i++) begin
				valid_q[i] <= 1'b0;
			end
			for (int i = 0; i < WORKERS; i++) begin
				total_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				aw_q <= cfg_wdata;
			end
			if (cmd.commit) begin
				if (do_alloc) begin
					valid_q[slot_q] <= 1'b1;
				end
				if (do_dec && cur_count == count_t'(1)) begin
					valid_q[slot_q] <= 1'b0;
				end
				if (do_inc || do_alloc) begin
					total_q[tw] <= total_q[tw] + total_t'(1);
				end
				if (do_dec) begin
					total_q[tw] <= total_q[tw] - total_t'(1);
				end
			end
		end
	end

	// Request capture, search progress, slot payload and result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q        <= in_tuser;
			dom_q        <= DOMAIN_BITS'(in_tdata[DOMAIN_IN_W-1:0]);
			fw_q         <= in_tdata[DOMAIN_IN_W +: FW_BITS];
			w_q          <= '0;
			last_q       <= last_c;
			best_q       <= '0;
			best_total_q <= '0;
			hit_q        <= 1'b0;
			found_q      <= 1'b0;
		end
		if (cmd.scan) begin
			if (row_any) begin
				hit_q    <= 1'b1;
				found_q  <= 1'b1;
				slot_q   <= row_slot;
				chosen_q <= w_q;
			end else begin
				if (w_q == '0 || total_q[w_q] < best_total_q) begin
					best_q       <= w_q;
					best_total_q <= total_q[w_q];
				end
				w_q <= w_q + worker_idx_t'(1);
			end
		end
		if (cmd.free_lookup) begin
			chosen_q <= best_q;
			found_q  <= free_any;
			slot_q   <= free_slot;
		end
		if (cmd.fin_lookup) begin
			found_q <= fw_ok && row_any;
			slot_q  <= row_slot;
		end
		if (cmd.commit) begin
			if (do_alloc) begin
				domain_q[slot_q] <= dom_q;
				count_q[slot_q]  <= count_t'(1);
			end
			if (do_inc) begin
				count_q[slot_q] <= cur_count + count_t'(1);
			end
			if (do_dec) begin
				count_q[slot_q] <= cur_count - count_t'(1);
			end
			out_chosen_q <= (cmd_q == CMD_FINISH) ? fw_q : CHOSEN_W'(chosen_q);
			out_hit_q    <= (cmd_q == CMD_ASSIGN) && hit_q;
			out_status_q <= status_c;
		end
	end

	// Bits from the low end: chosen_worker, affinity_hit, status, zero pad
	assign out_tdata = {{(OUT_TDATA_W - CHOSEN_W - 3){1'b0}}, out_status_q, out_hit_q,
		out_chosen_q};

	`DAD_ASSERT_IMP(a_fin_slot_live, clk, arst_n,
		cmd.commit && cmd_q == CMD_FINISH && found_q,
		valid_q[slot_q] && cur_count != '0)
	`DAD_ASSERT_IMP(a_alloc_slot_free, clk, arst_n, cmd.commit && do_alloc, !valid_q[slot_q])
	`DAD_ASSERT_IMP(a_scan_in_range, clk, arst_n, cmd.scan, w_q <= last_q)

endmodule

`default_nettype wire

>>> rtl/dad_ctrl.sv
// ----------------------------------------------------------------------------
// dad_ctrl
// Sequencer for lookup, worker scan and commit, plus result handshake.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dad_ctrl
	import dad_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_finish,
	output logic          in_ready,
	input  wire logic     out_ready,
	output logic          out_valid,
	output dp_cmd_t       cmd,
	input  wire dp_stat_t st
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_FREE   = 5'b00100,
		ST_FIN    = 5'b01000,
		ST_COMMIT = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   go;

	assign go        = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = in_finish ? ST_FIN : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (st.row_hit) begin
					state_d = ST_COMMIT;
				end else if (st.scan_last) begin
					state_d = ST_FREE;
				end
			end
			ST_FREE: begin
				cmd.free_lookup = 1'b1;
				state_d         = ST_COMMIT;
			end
			ST_FIN: begin
				cmd.fin_lookup = 1'b1;
				state_d        = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (go) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`DAD_ASSERT_NXT(a_hit_to_commit, clk, arst_n, state_q == ST_SCAN && st.row_hit,
		state_q == ST_COMMIT)
	`DAD_ASSERT_IMP(a_commit_slot_open, clk, arst_n, cmd.commit, !out_valid_q || out_ready)

endmodule

`default_nettype wire
